// ----- design/cvdm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package cvdm_pkg;

  // Field widths of the two channels.
  localparam int unsigned CH_W     = 4;
  localparam int unsigned CV_W     = 16;
  localparam int unsigned CORNER_W = 5;
  localparam int unsigned CODE_W   = 12;
  localparam int unsigned LED_W    = 13;

  // Calibration table geometry. Corners are split into an even and an odd bank,
  // so that the two corners of any segment sit in different banks.
  localparam int unsigned DEF_CHANNELS = 16;
  localparam int unsigned CORNERS      = 21;
  localparam int unsigned EVEN_ROWS    = (CORNERS + 1) / 2;
  localparam int unsigned ODD_ROWS     = CORNERS / 2;
  localparam int unsigned IDX_W        = $clog2(EVEN_ROWS);
  localparam int unsigned OFS_W        = 16;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_MODE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LED_ENABLE = 1'd1;

  typedef enum logic [1:0] {
    CMD_VOLT   = 2'd0,
    CMD_RAW    = 2'd1,
    CMD_CORNER = 2'd2
  } cvdm_cmd_t;

  // Voltage window and segment arithmetic.
  localparam logic signed [CV_W-1:0] CV_LIMIT    = 16'sd10000;
  localparam logic [14:0]            SEG_SPAN    = 15'd1000;
  // floor(pos / 1000) = (pos * SEG_RECIP) >> 24 for pos up to 20000.
  localparam logic [14:0]            SEG_RECIP   = 15'd16778;
  localparam logic [10:0]            MIX_SCALE   = 11'd1000;
  // floor(m / 1000) = (m * DIV1000_RECIP) >> 35 for m up to 2^25.
  localparam logic [25:0]            DIV1000_RECIP = 26'd34359739;
  // floor(t / 5) = (t * DIV5_RECIP) >> 21 for t below 2^18.
  localparam logic [18:0]            DIV5_RECIP  = 19'd419431;
  localparam logic signed [19:0]     SPAN10_BIAS = 20'sd10000;
  localparam logic signed [19:0]     SPAN5_BIAS  = 20'sd5000;

  // Code range and LED levels.
  localparam logic [CODE_W-1:0] CODE_MAX  = 12'd4095;
  localparam logic [CODE_W-1:0] LED_V_MID = 12'd2000;
  localparam logic [LED_W-1:0]  LED_V_TOP = 13'd4000;
  localparam logic [CODE_W-1:0] LED_R_MID = 12'd2048;
  localparam logic [LED_W-1:0]  LED_R_TOP = 13'd4096;

  typedef struct packed {
    cvdm_cmd_t                cmd;
    logic [CH_W-1:0]          channel;
    logic signed [CV_W-1:0]   cv_mv;
    logic                     soft_tune;
    logic signed [CV_W-1:0]   raw_code;
    logic [CORNER_W-1:0]      corner_index;
    logic signed [OFS_W-1:0]  corner_offset;
  } cvdm_item_t;

endpackage

`default_nettype wire

// ----- design/cvdm_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface cvdm_in_if;
  import cvdm_pkg::*;

  logic                           valid;
  logic                           ready;
  logic [1:0]                     cmd;
  logic [CH_W-1:0]                channel;
  logic signed [CV_W-1:0]         cv_mv;
  logic                           soft_tune;
  logic signed [CV_W-1:0]         raw_code;
  logic [CORNER_W-1:0]            corner_index;
  logic signed [OFS_W-1:0]        corner_offset;

  modport source (
    output valid, cmd, channel, cv_mv, soft_tune, raw_code, corner_index, corner_offset,
    input  ready
  );

  modport sink (
    input  valid, cmd, channel, cv_mv, soft_tune, raw_code, corner_index, corner_offset,
    output ready
  );

endinterface

`default_nettype wire

// ----- design/cvdm_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface cvdm_out_if;
  import cvdm_pkg::*;

  logic              valid;
  logic              ready;
  logic [CH_W-1:0]   dac_channel;
  logic [CODE_W-1:0] dac_code;
  logic              led_update;
  logic [LED_W-1:0]  led_level;

  modport source (
    output valid, dac_channel, dac_code, led_update, led_level,
    input  ready
  );

  modport sink (
    input  valid, dac_channel, dac_code, led_update, led_level,
    output ready
  );

endinterface

`default_nettype wire

// ----- design/cvdm_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cvdm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    // Read data holds while re is low, so a stalled reader keeps its word.
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- design/calibrated_cv_to_dac_mapper.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake     Payload
// in_if     sink       valid/ready   cmd, channel, cv_mv, soft_tune, raw_code,
//                                    corner_index, corner_offset
// out_if    source     valid/ready   dac_channel, dac_code, led_update, led_level
// cfg_*     write      cfg_we        cfg_index, cfg_wdata
//
// One transaction is accepted per cycle while out_if is not stalled and clearing is done.
// Its valid bit runs through the eight-stage pipeline (segment search, table read, two
// constant divisions by reciprocal multiply) and then through the output register.
// After reset a clearing pass zeroes the calibration banks, with in_if.ready low.
// A stall on out_if freezes the whole pipeline in place.
module calibrated_cv_to_dac_mapper #(
  parameter int unsigned CHANNELS = cvdm_pkg::DEF_CHANNELS
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  cvdm_in_if.sink                               in_if,
  cvdm_out_if.source                            out_if,
  input  wire logic                             cfg_we,
  input  wire logic [cvdm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [cvdm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import cvdm_pkg::*;

  localparam int unsigned NSTG       = 8;
  localparam int unsigned EVEN_DEPTH = CHANNELS * EVEN_ROWS;
  localparam int unsigned ODD_DEPTH  = CHANNELS * ODD_ROWS;
  localparam int unsigned EAW        = $clog2(EVEN_DEPTH);
  localparam int unsigned OAW        = $clog2(ODD_DEPTH);
  localparam int unsigned BASE_W     = CH_W + IDX_W + 1;

  // Configuration registers.
  logic gain_mode_r;
  logic led_enable_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_mode_r  <= 1'b1;
      led_enable_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GAIN_MODE:  gain_mode_r  <= cfg_wdata[0];
        CFG_LED_ENABLE: led_enable_r <= cfg_wdata[0];
      endcase
    end
  end

  // Clearing pass over both banks.
  logic           clearing_r;
  logic [EAW-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      if (clr_addr_r == EAW'(EVEN_DEPTH - 1)) begin
        clearing_r <= 1'b0;
      end
      clr_addr_r <= clr_addr_r + EAW'(1);
    end
  end

  // Handshake and pipeline advance.
  logic out_valid_r;
  logic adv;
  logic acc;

  assign adv         = !out_valid_r || out_if.ready;
  assign in_if.ready = adv && !clearing_r;
  assign acc         = in_if.valid && in_if.ready;

  cvdm_item_t in_item;

  always_comb begin
    in_item.cmd           = cvdm_cmd_t'(in_if.cmd);
    in_item.channel       = in_if.channel;
    in_item.cv_mv         = in_if.cv_mv;
    in_item.soft_tune     = in_if.soft_tune;
    in_item.raw_code      = in_if.raw_code;
    in_item.corner_index  = in_if.corner_index;
    in_item.corner_offset = in_if.corner_offset;
  end

  logic [NSTG:1] vld_r;
  cvdm_item_t    item_r [1:NSTG];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NSTG-1:1], acc};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      item_r[1] <= in_item;
      for (int i = 2; i <= NSTG; i++) begin
        item_r[i] <= item_r[i-1];
      end
    end
  end

  // Stage 1: clamp the request and find its 1 V segment.
  logic signed [CV_W-1:0] clamp1;
  logic [16:0]            pos1_w;
  logic [14:0]            pos1;
  logic [29:0]            segp1_w;
  logic [4:0]             seg_nxt;
  logic [14:0]            pos2_r;
  logic [4:0]             seg2_r;

  always_comb begin
    if (item_r[1].cv_mv < -CV_LIMIT) begin
      clamp1 = -CV_LIMIT;
    end else if (item_r[1].cv_mv > CV_LIMIT) begin
      clamp1 = CV_LIMIT;
    end else begin
      clamp1 = item_r[1].cv_mv;
    end
    pos1_w  = {clamp1[CV_W-1], clamp1} + 17'd10000;
    pos1    = pos1_w[14:0];
    segp1_w = 30'(pos1) * 30'(SEG_RECIP);
    seg_nxt = segp1_w[28:24];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pos2_r <= pos1;
      seg2_r <= seg_nxt;
    end
  end

  // Stage 2: fraction within the segment, table addresses and corner writes.
  logic [14:0]       f2_w;
  logic [9:0]        f2;
  logic              chok2;
  logic [IDX_W-1:0]  even_idx2;
  logic [IDX_W-1:0]  odd_raw2;
  logic [IDX_W-1:0]  odd_idx2;
  logic [IDX_W-1:0]  wr_idx2;
  logic              wr_ok2;
  logic [BASE_W-1:0] ebase2;
  logic [BASE_W-1:0] obase2;
  logic [EAW-1:0]    e_raddr;
  logic [EAW-1:0]    e_waddr;
  logic [OAW-1:0]    o_raddr;
  logic [OAW-1:0]    o_waddr;
  logic              e_we;
  logic              o_we;
  logic [EAW-1:0]    e_wa;
  logic [OAW-1:0]    o_wa;
  logic [OFS_W-1:0]  wdata2;
  logic [9:0]        f3_r;
  logic              swap3_r;
  logic              chok3_r;

  always_comb begin
    f2_w      = pos2_r - 15'(seg2_r) * SEG_SPAN;
    f2        = f2_w[9:0];
    chok2     = 32'(item_r[2].channel) < CHANNELS;
    even_idx2 = IDX_W'((6'(seg2_r) + 6'd1) >> 1);
    odd_raw2  = IDX_W'(seg2_r >> 1);
    // At the top of the range the odd corner has zero weight; keep its address legal.
    odd_idx2  = (odd_raw2 > IDX_W'(ODD_ROWS - 1)) ? IDX_W'(ODD_ROWS - 1) : odd_raw2;
    wr_idx2   = IDX_W'(item_r[2].corner_index >> 1);
    wr_ok2    = adv && vld_r[2] && (item_r[2].cmd == CMD_CORNER) && chok2 &&
                (item_r[2].corner_index <= CORNER_W'(CORNERS - 1));
    ebase2    = BASE_W'(item_r[2].channel) * BASE_W'(EVEN_ROWS);
    obase2    = BASE_W'(item_r[2].channel) * BASE_W'(ODD_ROWS);
    e_raddr   = chok2 ? EAW'(ebase2 + BASE_W'(even_idx2)) : '0;
    o_raddr   = chok2 ? OAW'(obase2 + BASE_W'(odd_idx2))  : '0;
    e_waddr   = chok2 ? EAW'(ebase2 + BASE_W'(wr_idx2))   : '0;
    o_waddr   = chok2 ? OAW'(obase2 + BASE_W'(wr_idx2))   : '0;

    e_we   = clearing_r || (wr_ok2 && !item_r[2].corner_index[0]);
    o_we   = (clearing_r && (32'(clr_addr_r) < ODD_DEPTH)) ||
             (wr_ok2 && item_r[2].corner_index[0]);
    e_wa   = clearing_r ? clr_addr_r : e_waddr;
    o_wa   = clearing_r ? OAW'(clr_addr_r) : o_waddr;
    wdata2 = clearing_r ? '0 : item_r[2].corner_offset;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f3_r    <= f2;
      swap3_r <= seg2_r[0];
      chok3_r <= chok2;
    end
  end

  logic [OFS_W-1:0] even_rd;
  logic [OFS_W-1:0] odd_rd;

  cvdm_ram #(
    .WIDTH (OFS_W),
    .DEPTH (EVEN_DEPTH)
  ) u_even_bank (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_wa),
    .wdata (wdata2),
    .re    (adv),
    .raddr (e_raddr),
    .rdata (even_rd)
  );

  cvdm_ram #(
    .WIDTH (OFS_W),
    .DEPTH (ODD_DEPTH)
  ) u_odd_bank (
    .clk   (clk),
    .we    (o_we),
    .waddr (o_wa),
    .wdata (wdata2),
    .re    (adv),
    .raddr (o_raddr),
    .rdata (odd_rd)
  );

  // Stage 3: weight the two corners.
  logic signed [OFS_W-1:0] o0_3;
  logic signed [OFS_W-1:0] o1_3;
  logic [9:0]              w0_3;
  logic signed [26:0]      pa_nxt;
  logic signed [26:0]      pb_nxt;
  logic signed [26:0]      pa4_r;
  logic signed [26:0]      pb4_r;

  always_comb begin
    if (!chok3_r) begin
      o0_3 = '0;
      o1_3 = '0;
    end else if (swap3_r) begin
      o0_3 = $signed(odd_rd);
      o1_3 = $signed(even_rd);
    end else begin
      o0_3 = $signed(even_rd);
      o1_3 = $signed(odd_rd);
    end
    w0_3   = 10'(MIX_SCALE - 11'(f3_r));
    pa_nxt = 27'($signed({1'b0, w0_3})) * 27'(o0_3);
    pb_nxt = 27'($signed({1'b0, f3_r})) * 27'(o1_3);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pa4_r <= pa_nxt;
      pb4_r <= pb_nxt;
    end
  end

  // Stage 4: sum and split into sign and magnitude, so that the division truncates
  // toward zero.
  logic signed [27:0] mix4;
  logic [27:0]        mag4_w;
  logic [25:0]        mag5_r;
  logic               neg5_r;

  always_comb begin
    mix4   = 28'(pa4_r) + 28'(pb4_r);
    mag4_w = mix4[27] ? 28'(-mix4) : 28'(mix4);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mag5_r <= mag4_w[25:0];
      neg5_r <= mix4[27];
    end
  end

  // Stage 5: divide by 1000.
  logic [51:0] q5_w;
  logic [15:0] q6_r;
  logic        neg6_r;

  assign q5_w = 52'(mag5_r) * 52'(DIV1000_RECIP);

  always_ff @(posedge clk) begin
    if (adv) begin
      q6_r   <= q5_w[50:35];
      neg6_r <= neg5_r;
    end
  end

  // Stage 6: apply the offset and bias into the selected span.
  logic signed [16:0] off6;
  logic signed [17:0] v6;
  logic signed [19:0] t6;
  logic [19:0]        tmag6_w;
  logic [18:0]        tmag7_r;
  logic               tneg7_r;

  always_comb begin
    off6 = neg6_r ? -$signed({1'b0, q6_r}) : $signed({1'b0, q6_r});
    v6   = 18'($signed(item_r[6].cv_mv));
    if (item_r[6].soft_tune) begin
      v6 = v6 + 18'(off6);
    end
    // Gain mode 1 needs (v+10000)/5, gain mode 0 needs 2*(v+5000)/5.
    if (gain_mode_r) begin
      t6 = 20'(v6) + SPAN10_BIAS;
    end else begin
      t6 = (20'(v6) + SPAN5_BIAS) <<< 1;
    end
    tmag6_w = t6[19] ? 20'(-t6) : 20'(t6);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tmag7_r <= tmag6_w[18:0];
      tneg7_r <= t6[19];
    end
  end

  // Stage 7: divide by 5.
  logic [39:0] q7_w;
  logic [15:0] q8_r;
  logic        tneg8_r;

  assign q7_w = 40'(tmag7_r) * 40'(DIV5_RECIP);

  always_ff @(posedge clk) begin
    if (adv) begin
      q8_r    <= q7_w[36:21];
      tneg8_r <= tneg7_r;
    end
  end

  // Stage 8: invert, saturate and derive the LED level.
  logic signed [16:0] qs8;
  logic signed [17:0] d8;
  logic [CODE_W-1:0]  vcode8;
  logic [CODE_W-1:0]  rcode8;
  logic [CODE_W-1:0]  code_nxt;
  logic [LED_W-1:0]   led8;
  logic [LED_W-1:0]   led_nxt;
  logic               emit8;

  always_comb begin
    qs8 = tneg8_r ? -$signed({1'b0, q8_r}) : $signed({1'b0, q8_r});
    d8  = 18'($signed({6'd0, CODE_MAX})) - 18'(qs8);
    if (d8 < 0) begin
      vcode8 = '0;
    end else if (d8 > 18'($signed({6'd0, CODE_MAX}))) begin
      vcode8 = CODE_MAX;
    end else begin
      vcode8 = d8[CODE_W-1:0];
    end

    if (item_r[8].raw_code < 0) begin
      rcode8 = '0;
    end else if (item_r[8].raw_code > 16'($signed({4'd0, CODE_MAX}))) begin
      rcode8 = CODE_MAX;
    end else begin
      rcode8 = item_r[8].raw_code[CODE_W-1:0];
    end

    if (item_r[8].cmd == CMD_VOLT) begin
      code_nxt = vcode8;
      if (item_r[8].cv_mv == 0) begin
        led8 = '0;
      end else if (vcode8 < LED_V_MID) begin
        led8 = LED_V_TOP - {vcode8, 1'b0};
      end else begin
        led8 = {vcode8 - LED_V_MID, 1'b0};
      end
    end else begin
      code_nxt = rcode8;
      if (rcode8 < LED_R_MID) begin
        led8 = LED_R_TOP - {rcode8, 1'b0};
      end else begin
        led8 = {rcode8 - LED_R_MID, 1'b0};
      end
    end

    led_nxt = led_enable_r ? led8 : '0;
    emit8   = vld_r[NSTG] &&
              ((item_r[NSTG].cmd == CMD_VOLT) || (item_r[NSTG].cmd == CMD_RAW));
  end

  // Output register.
  logic [CH_W-1:0]   dac_channel_r;
  logic [CODE_W-1:0] dac_code_r;
  logic              led_update_r;
  logic [LED_W-1:0]  led_level_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= emit8;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dac_channel_r <= item_r[NSTG].channel;
      dac_code_r    <= code_nxt;
      led_update_r  <= led_enable_r;
      led_level_r   <= led_nxt;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.dac_channel = dac_channel_r;
  assign out_if.dac_code    = dac_code_r;
  assign out_if.led_update  = led_update_r;
  assign out_if.led_level   = led_level_r;

endmodule

`default_nettype wire

// ----- tb/cvdm_checker.sv -----
`timescale 1ns / 1ps

module cvdm_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  cvdm_in_if                              in_mon,
  cvdm_out_if                             out_mon,
  input  logic                            cfg_we,
  input  logic [cvdm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cvdm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int unsigned                     mismatches,
  output int unsigned                     awaiting
);
  import cvdm_pkg::*;

  typedef struct packed {
    logic [CH_W-1:0]   ch;
    logic [CODE_W-1:0] code;
    logic              led_upd;
    logic [LED_W-1:0]  led;
  } dac_result_t;

  logic                    gain_wide;
  logic                    led_on;
  logic signed [OFS_W-1:0] cal_offsets [DEF_CHANNELS][CORNERS];
  dac_result_t             expected_dac[$];

  function automatic dac_result_t map_request(input cvdm_item_t req);
    dac_result_t r;
    longint      v, q, code, lvl, o0, o1, mix, off;
    int          clamped, pos, seg, f;
    lvl = 0;
    if (req.cmd == CMD_VOLT) begin
      v = longint'(req.cv_mv);
      if (req.soft_tune) begin
        clamped = (v < -10000) ? -10000 : ((v > 10000) ? 10000 : int'(v));
        pos = clamped + 10000;
        seg = pos / 1000;
        if (seg >= 20) begin
          off = longint'(cal_offsets[req.channel][20]);
        end else begin
          f = pos - seg * 1000;
          o0 = longint'(cal_offsets[req.channel][seg]);
          o1 = longint'(cal_offsets[req.channel][seg + 1]);
          mix = longint'(1000 - f) * o0 + longint'(f) * o1;
          // Signed division truncates toward zero, as the offset requires.
          off = mix / 1000;
        end
        v = v + off;
      end
      if (gain_wide) q = ((v + 10000) * 4000) / 20000;
      else q = ((v + 5000) * 4000) / 10000;
      code = 4095 - q;
      if (code < 0) code = 0;
      else if (code > 4095) code = 4095;
      if (led_on && req.cv_mv != 0)
        lvl = (code < 2000) ? 4000 - 2 * code : (code - 2000) * 2;
    end else begin
      code = longint'(req.raw_code);
      if (code < 0) code = 0;
      else if (code > 4095) code = 4095;
      if (led_on) lvl = (code < 2048) ? 4096 - 2 * code : (code - 2048) * 2;
    end
    r.ch = req.channel;
    r.code = CODE_W'(code);
    r.led_upd = led_on;
    r.led = LED_W'(lvl);
    return r;
  endfunction

  task automatic flag_result(input string why, input dac_result_t want,
                             input dac_result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t %s: channel exp %0d got %0d, code exp %0d got %0d",
               $time, why, want.ch, got.ch, want.code, got.code);
      $display("  led_update exp %0d got %0d, led_level exp %0d got %0d",
               want.led_upd, got.led_upd, want.led, got.led);
    end
  endtask

  always @(posedge clk) begin
    cvdm_item_t  req;
    dac_result_t got;
    dac_result_t want;
    if (!rst_n) begin
      gain_wide = 1'b1;
      led_on = 1'b0;
      foreach (cal_offsets[c, k]) cal_offsets[c][k] = '0;
      expected_dac.delete();
      mismatches = 0;
    end else begin
      // Results leave long after their request, so the output side is handled first.
      if (out_mon.valid && out_mon.ready) begin
        got.ch = out_mon.dac_channel;
        got.code = out_mon.dac_code;
        got.led_upd = out_mon.led_update;
        got.led = out_mon.led_level;
        if (expected_dac.size() == 0) begin
          flag_result("result with nothing awaited", '0, got);
        end else begin
          want = expected_dac.pop_front();
          if (got.ch != want.ch || got.code != want.code ||
              got.led_upd != want.led_upd || got.led != want.led)
            flag_result("result mismatch", want, got);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        req.cmd = cvdm_cmd_t'(in_mon.cmd);
        req.channel = in_mon.channel;
        req.cv_mv = in_mon.cv_mv;
        req.soft_tune = in_mon.soft_tune;
        req.raw_code = in_mon.raw_code;
        req.corner_index = in_mon.corner_index;
        req.corner_offset = in_mon.corner_offset;
        if (req.cmd == CMD_CORNER) begin
          if (req.corner_index < CORNERS)
            cal_offsets[req.channel][req.corner_index] = req.corner_offset;
        end else if (req.cmd == CMD_VOLT || req.cmd == CMD_RAW) begin
          expected_dac.push_back(map_request(req));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_GAIN_MODE:  gain_wide = cfg_wdata[0];
          CFG_LED_ENABLE: led_on = cfg_wdata[0];
          default: ;
        endcase
      end
    end
    awaiting = expected_dac.size();
  end

endmodule

// ----- tb/tb_calibrated_cv_to_dac_mapper.sv -----
`timescale 1ns / 1ps

module tb_calibrated_cv_to_dac_mapper;
  import cvdm_pkg::*;

  localparam logic [1:0] CMD_UNUSED     = 2'd3;
  localparam int         RANDOM_ITEMS   = 2000;
  localparam int         BLOCKS         = 6;
  localparam int         HOLD_CYCLES    = 400;
  localparam int         SETTLE_CYCLES  = 12;
  localparam int         WATCHDOG_LIMIT = 3000;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int unsigned           mismatches;
  int unsigned           awaiting;
  int unsigned           snd_idle;
  int unsigned           rcv_idle;
  int unsigned           stall_cycles;
  bit                    hold_req;

  cvdm_in_if  in_ch ();
  cvdm_out_if out_ch ();

  calibrated_cv_to_dac_mapper dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  cvdm_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .awaiting   (awaiting)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic cvdm_item_t mk_item(input logic [1:0] cmd, input int ch, input int cv,
                                         input bit tune_on, input int raw, input int idx,
                                         input int ofs);
    cvdm_item_t it;
    it.cmd = cvdm_cmd_t'(cmd);
    it.channel = ch[CH_W-1:0];
    it.cv_mv = cv[CV_W-1:0];
    it.soft_tune = tune_on;
    it.raw_code = raw[CV_W-1:0];
    it.corner_index = idx[CORNER_W-1:0];
    it.corner_offset = ofs[OFS_W-1:0];
    return it;
  endfunction

  function automatic cvdm_item_t rand_item();
    int unsigned pick;
    logic [1:0]  cmd;
    int          ch, cv, raw, idx, ofs;
    pick = $urandom_range(99);
    if (pick < 42) cmd = CMD_VOLT;
    else if (pick < 72) cmd = CMD_RAW;
    else if (pick < 95) cmd = CMD_CORNER;
    else cmd = CMD_UNUSED;
    // Most traffic goes to a few channels so that written corners are read back.
    ch = ($urandom_range(99) < 60) ? int'($urandom_range(3)) : int'($urandom_range(15));
    pick = $urandom_range(99);
    if (pick < 55) cv = int'($urandom_range(24000)) - 12000;
    else if (pick < 70) cv = (int'($urandom_range(20)) - 10) * 1000 + int'($urandom_range(4)) - 2;
    else if (pick < 75) cv = ($urandom_range(1) != 0) ? -32768 : 32767;
    else cv = int'($urandom_range(65535));
    pick = $urandom_range(99);
    if (pick < 50) raw = int'($urandom_range(4400)) - 150;
    else if (pick < 60) raw = ($urandom_range(1) != 0) ? -32768 : 32767;
    else raw = int'($urandom_range(65535));
    idx = ($urandom_range(99) < 85) ? int'($urandom_range(20)) : int'($urandom_range(31));
    ofs = ($urandom_range(99) < 70) ? int'($urandom_range(1200)) - 600
                                    : int'($urandom_range(65535));
    return mk_item(cmd, ch, cv, $urandom_range(1) != 0, raw, idx, ofs);
  endfunction

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_item(input cvdm_item_t it);
    while ($urandom_range(99) < snd_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= it.cmd;
    in_ch.channel <= it.channel;
    in_ch.cv_mv <= it.cv_mv;
    in_ch.soft_tune <= it.soft_tune;
    in_ch.raw_code <= it.raw_code;
    in_ch.corner_index <= it.corner_index;
    in_ch.corner_offset <= it.corner_offset;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Table writes and unused commands leave no result, so the bench still waits
  // after the last result before the block is taken to be idle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (awaiting != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_regs(input bit gain, input bit led);
    cfg_we <= 1'b1;
    cfg_index <= CFG_GAIN_MODE;
    cfg_wdata <= gain;
    @(negedge clk);
    cfg_index <= CFG_LED_ENABLE;
    cfg_wdata <= led;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(input int count, input bit with_hold);
    cvdm_item_t it;
    int         done;
    done = 0;
    while (done < count) begin
      it = rand_item();
      if (with_hold && done == count / 2) hold_req = 1'b1;
      send_item(it);
      if (!(it.cmd == cvdm_cmd_t'(CMD_UNUSED) ||
            (it.cmd == CMD_CORNER && it.corner_index >= CORNERS)))
        done++;
    end
  endtask

  task automatic run_directed();
    // Corners at both ends of the table, including the largest offsets.
    send_item(mk_item(CMD_CORNER, 3, 0, 0, 0, 0, -32768));
    send_item(mk_item(CMD_CORNER, 3, 0, 0, 0, 1, 32767));
    send_item(mk_item(CMD_CORNER, 3, 0, 0, 0, 19, 500));
    send_item(mk_item(CMD_CORNER, 3, 0, 0, 0, 20, -250));
    // A corner beyond the table must be ignored.
    send_item(mk_item(CMD_CORNER, 3, 0, 0, 0, 31, 1234));
    send_item(mk_item(CMD_VOLT, 3, -32768, 1, 0, 0, 0));
    send_item(mk_item(CMD_VOLT, 3, 32767, 1, 0, 0, 0));
    send_item(mk_item(CMD_VOLT, 3, 10000, 1, 0, 0, 0));
    send_item(mk_item(CMD_VOLT, 3, -10000, 1, 0, 0, 0));
    send_item(mk_item(CMD_VOLT, 3, -9500, 1, 0, 0, 0));
    send_item(mk_item(CMD_VOLT, 3, 9999, 1, 0, 0, 0));
    send_item(mk_item(CMD_VOLT, 5, 0, 0, 0, 0, 0));
    send_item(mk_item(CMD_VOLT, 3, 0, 1, 0, 0, 0));
    send_item(mk_item(CMD_VOLT, 15, 5000, 0, 0, 0, 0));
    send_item(mk_item(CMD_VOLT, 0, -5000, 0, 0, 0, 0));
    send_item(mk_item(CMD_RAW, 1, 0, 0, -32768, 0, 0));
    send_item(mk_item(CMD_RAW, 2, 0, 0, 32767, 0, 0));
    send_item(mk_item(CMD_RAW, 4, 0, 0, 0, 0, 0));
    send_item(mk_item(CMD_RAW, 6, 0, 0, 2047, 0, 0));
    send_item(mk_item(CMD_RAW, 7, 0, 0, 2048, 0, 0));
    send_item(mk_item(CMD_RAW, 8, 0, 0, 4095, 0, 0));
    send_item(mk_item(CMD_RAW, 9, 0, 0, 4096, 0, 0));
    send_item(mk_item(CMD_UNUSED, 10, 1000, 1, 1000, 0, 0));
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rcv_idle);
      end
    end
  end

  initial begin
    stall_cycles = 0;
    while (stall_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    bit gains [BLOCKS];
    bit leds  [BLOCKS];
    gains = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    leds  = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0};
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.cmd = '0;
    in_ch.channel = '0;
    in_ch.cv_mv = '0;
    in_ch.soft_tune = 1'b0;
    in_ch.raw_code = '0;
    in_ch.corner_index = '0;
    in_ch.corner_offset = '0;
    snd_idle = 0;
    rcv_idle = 0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // The calibration table is cleared after reset; the input stays closed until then.
    while (!in_ch.ready) @(negedge clk);
    write_regs(1'b1, 1'b1);
    run_directed();
    drain();
    for (int blk = 0; blk < BLOCKS; blk++) begin
      case (blk / 2)
        0: begin
          snd_idle = 27;
          rcv_idle = 83;
        end
        1: begin
          snd_idle = 83;
          rcv_idle = 27;
        end
        default: begin
          snd_idle = 0;
          rcv_idle = 0;
        end
      endcase
      write_regs(gains[blk], leds[blk]);
      run_random(RANDOM_ITEMS / BLOCKS, blk == BLOCKS - 2);
      drain();
    end
    if (mismatches == 0 && awaiting == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
